// File: src/omr_pkg.sv
// Shared types, constants and the square-root step for the obstacle mask rasterizer.
// Used by every module of the block; depends on nothing else.
package omr_pkg;

  // Configuration register indexes.
  localparam logic [3:0] REG_SHAPE_MODE    = 4'd0;
  localparam logic [3:0] REG_CENTER_X      = 4'd1;
  localparam logic [3:0] REG_CENTER_Y      = 4'd2;
  localparam logic [3:0] REG_CIRCLE_RADIUS = 4'd3;
  localparam logic [3:0] REG_HALF_WIDTH    = 4'd4;
  localparam logic [3:0] REG_HALF_HEIGHT   = 4'd5;
  localparam logic [3:0] REG_VEL_X         = 4'd6;
  localparam logic [3:0] REG_VEL_Y         = 4'd7;

  // Shape selection codes.
  localparam logic SHAPE_CIRCLE = 1'b0;
  localparam logic SHAPE_RECT   = 1'b1;

  // Occupancy levels in unsigned Q0.16.
  localparam logic [15:0] OCC_BORDER = 16'd13107;
  localparam logic [15:0] OCC_FULL   = 16'd58982;

  // Number of square-root stages; each stage resolves two root bits.
  localparam int SQRT_STAGES = 8;

  // Per-pixel flags that travel with the data down the pipeline.
  typedef struct packed {
    logic in_grid;
    logic border;
    logic rect_hit;
    logic circ_hit;
  } side_t;

  // Output of the front end: flags and the squared distance (valid when covered).
  typedef struct packed {
    side_t       side;
    logic [15:0] rad;
  } front_t;

  // Partial square-root state.
  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } sq_t;

  // One digit-by-digit square-root step that brings in two radicand bits.
  function automatic sq_t sqrt_step(sq_t cur, logic [1:0] bits);
    logic [19:0] t;
    logic [19:0] trial;
    logic [19:0] diff;
    sq_t         nxt;
    t     = {cur.rem, bits};
    trial = {2'b00, cur.root, 2'b01};
    diff  = t - trial;
    if (t >= trial) begin
      nxt.rem  = diff[17:0];
      nxt.root = {cur.root[14:0], 1'b1};
    end else begin
      nxt.rem  = t[17:0];
      nxt.root = {cur.root[14:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// File: src/obstacle_mask_rasterizer.sv
// Top level of the obstacle mask rasterizer: configuration registers and pipeline.
// Depends on omr_pkg, omr_front, omr_sqrt and omr_shade.

// Shades one grid pixel per transaction and streams at one pixel per clock when
// the output is not stalled. Every pixel goes through a fourteen-stage pipeline:
// three front stages (grid, rectangle and distance tests), eight square-root stages
// that each resolve two bits of the Q.8 distance, and three back stages (rim ramp
// multiply, rounding and the output register). A stall on the output holds every
// stage in place; the input stall rises only once all stages are full.
// Configuration registers are read live by the pipeline, so write them only while no
// transaction is in flight.
module obstacle_mask_rasterizer #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         pixel_x,
  input  logic [9:0]         pixel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        occupancy,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic               inside_obstacle
);
  import omr_pkg::*;

  logic               shape_mode;
  logic [9:0]         center_x;
  logic [9:0]         center_y;
  logic [7:0]         circle_radius;
  logic [9:0]         half_width;
  logic [9:0]         half_height;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;

  logic    front_ready, front_valid;
  front_t  front_data;
  logic    sqrt_ready, sqrt_valid;
  side_t   sqrt_side;
  logic [15:0] sqrt_root;
  logic    shade_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode    <= SHAPE_CIRCLE;
      center_x      <= 10'd128;
      center_y      <= 10'd128;
      circle_radius <= 8'd16;
      half_width    <= 10'd16;
      half_height   <= 10'd16;
      vel_x         <= 16'sd0;
      vel_y         <= 16'sd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHAPE_MODE:    shape_mode    <= cfg_data[0];
        REG_CENTER_X:      center_x      <= cfg_data[9:0];
        REG_CENTER_Y:      center_y      <= cfg_data[9:0];
        REG_CIRCLE_RADIUS: circle_radius <= cfg_data[7:0];
        REG_HALF_WIDTH:    half_width    <= cfg_data[9:0];
        REG_HALF_HEIGHT:   half_height   <= cfg_data[9:0];
        REG_VEL_X:         vel_x         <= $signed(cfg_data);
        REG_VEL_Y:         vel_y         <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !front_ready;

  // Grid, rectangle and circle tests.
  omr_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (front_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .center_x      (center_x),
    .center_y      (center_y),
    .circle_radius (circle_radius),
    .half_width    (half_width),
    .half_height   (half_height),
    .out_valid     (front_valid),
    .out_ready     (sqrt_ready),
    .out_data      (front_data)
  );

  // Distance to the center in Q.8.
  omr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (sqrt_ready),
    .in_data   (front_data),
    .out_valid (sqrt_valid),
    .out_ready (shade_ready),
    .out_side  (sqrt_side),
    .out_root  (sqrt_root)
  );

  // Ramp, selection and output register.
  omr_shade u_shade (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (sqrt_valid),
    .in_ready        (shade_ready),
    .in_side         (sqrt_side),
    .in_root         (sqrt_root),
    .shape_mode      (shape_mode),
    .circle_radius   (circle_radius),
    .vel_x           (vel_x),
    .vel_y           (vel_y),
    .out_valid       (out_valid),
    .out_ready       (!out_stall),
    .occupancy       (occupancy),
    .out_vel_x       (out_vel_x),
    .out_vel_y       (out_vel_y),
    .inside_obstacle (inside_obstacle)
  );

endmodule

// File: src/omr_front.sv
// Front end of the rasterizer: grid and rectangle tests, distance squares, circle test.
// Three register stages; depends on omr_pkg.
module omr_front #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [9:0]             pixel_x,
  input  logic [9:0]             pixel_y,
  input  logic [9:0]             center_x,
  input  logic [9:0]             center_y,
  input  logic [7:0]             circle_radius,
  input  logic [9:0]             half_width,
  input  logic [9:0]             half_height,
  output logic                   out_valid,
  input  logic                   out_ready,
  output omr_pkg::front_t        out_data
);
  import omr_pkg::*;

  localparam logic [10:0] X_LIMIT = 11'(GRID_WIDTH);
  localparam logic [10:0] Y_LIMIT = 11'(GRID_HEIGHT);
  localparam logic [9:0]  X_LAST  = 10'(GRID_WIDTH - 1);
  localparam logic [9:0]  Y_LAST  = 10'(GRID_HEIGHT - 1);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // Stage 1 signals.
  logic signed [10:0] dx_c, dy_c;
  logic signed [11:0] px_s, py_s, x_lo, x_hi, y_lo, y_hi;
  side_t              side_c;
  logic signed [10:0] dx1, dy1;
  side_t              side1;

  // Stage 2 signals.
  logic signed [21:0] sqx_full, sqy_full;
  logic [15:0]        rr_c;
  logic [19:0]        sqx2, sqy2;
  logic [15:0]        rr2;
  side_t              side2;

  // Stage 3 signals.
  logic [20:0]        d2_c;
  side_t              side3_c;
  front_t             data3;

  // Stage handshake: a stage takes new data when empty or when it drains.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Offsets from the center and the rectangle bounds.
  assign dx_c = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x});
  assign dy_c = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y});
  assign px_s = $signed({2'b00, pixel_x});
  assign py_s = $signed({2'b00, pixel_y});
  assign x_lo = $signed({2'b00, center_x}) - $signed({2'b00, half_width});
  assign x_hi = $signed({2'b00, center_x}) + $signed({2'b00, half_width});
  assign y_lo = $signed({2'b00, center_y}) - $signed({2'b00, half_height});
  assign y_hi = $signed({2'b00, center_y}) + $signed({2'b00, half_height});

  always_comb begin
    side_c.in_grid  = ({1'b0, pixel_x} < X_LIMIT) && ({1'b0, pixel_y} < Y_LIMIT);
    side_c.border   = (pixel_x == 10'd0) || (pixel_y == 10'd0) ||
                      (pixel_x == X_LAST) || (pixel_y == Y_LAST);
    side_c.rect_hit = (px_s >= x_lo) && (px_s < x_hi) && (py_s >= y_lo) && (py_s < y_hi);
    side_c.circ_hit = 1'b0;
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      dx1   <= dx_c;
      dy1   <= dy_c;
      side1 <= side_c;
    end
  end

  // Squares of the offsets and of the radius.
  assign sqx_full = dx1 * dx1;
  assign sqy_full = dy1 * dy1;
  assign rr_c     = {8'b0, circle_radius} * {8'b0, circle_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      sqx2  <= sqx_full[19:0];
      sqy2  <= sqy_full[19:0];
      rr2   <= rr_c;
      side2 <= side1;
    end
  end

  // Squared distance and the circle coverage test.
  assign d2_c = {1'b0, sqx2} + {1'b0, sqy2};

  always_comb begin
    side3_c          = side2;
    side3_c.circ_hit = (d2_c <= {5'b0, rr2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      data3.side <= side3_c;
      data3.rad  <= d2_c[15:0];
    end
  end

  assign out_valid = v3;
  assign out_data  = data3;

endmodule

// File: src/omr_sqrt.sv
// Pipelined integer square root of the squared distance scaled by 65536.
// Eight stages of two root bits each; depends on omr_pkg.
module omr_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  omr_pkg::front_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output omr_pkg::side_t    out_side,
  output logic [15:0]       out_root
);
  import omr_pkg::*;

  logic        v    [SQRT_STAGES];
  logic        rdy  [SQRT_STAGES];
  sq_t         st   [SQRT_STAGES];
  logic [15:0] rad  [SQRT_STAGES];
  side_t       side [SQRT_STAGES];

  genvar k;
  generate
    for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic        src_v;
      sq_t         src_st;
      logic [15:0] src_rad;
      side_t       src_side;
      sq_t         mid;
      sq_t         nxt;

      // Source of this stage: the input port or the previous stage.
      if (k == 0) begin : g_first
        assign src_v    = in_valid;
        assign src_st   = '0;
        assign src_rad  = in_data.rad;
        assign src_side = in_data.side;
      end else begin : g_next
        assign src_v    = v[k-1];
        assign src_st   = st[k-1];
        assign src_rad  = rad[k-1];
        assign src_side = side[k-1];
      end

      if (k == SQRT_STAGES - 1) begin : g_last_rdy
        assign rdy[k] = !v[k] || out_ready;
      end else begin : g_mid_rdy
        assign rdy[k] = !v[k] || rdy[k+1];
      end

      // Two root bits per stage; the low half of the radicand is all zeros.
      always_comb begin
        mid = sqrt_step(src_st, src_rad[15:14]);
        nxt = sqrt_step(mid, src_rad[13:12]);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (rdy[k]) begin
          v[k] <= src_v;
        end
        if (rdy[k] && src_v) begin
          st[k]   <= nxt;
          rad[k]  <= {src_rad[11:0], 4'b0000};
          side[k] <= src_side;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v[SQRT_STAGES-1];
  assign out_side  = side[SQRT_STAGES-1];
  assign out_root  = st[SQRT_STAGES-1].root;

endmodule

// File: src/omr_shade.sv
// Back end of the rasterizer: rim ramp, shape selection and the output register.
// Three register stages; depends on omr_pkg.
module omr_shade (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  omr_pkg::side_t     in_side,
  input  logic [15:0]        in_root,
  input  logic               shape_mode,
  input  logic [7:0]         circle_radius,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        occupancy,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic               inside_obstacle
);
  import omr_pkg::*;

  logic va, vb, vc;
  logic rdya, rdyb, rdyc;

  logic [16:0] diff_c;
  logic [8:0]  diffa;
  logic        fulla;
  side_t       sidea;

  logic [24:0] prod_c;
  logic [24:0] prodb;
  logic        fullb;
  side_t       sideb;

  logic [24:0] round_c;
  logic        covered_c;
  logic [15:0] occ_c;

  assign rdyc     = !vc || out_ready;
  assign rdyb     = !vb || rdyc;
  assign rdya     = !va || rdyb;
  assign in_ready = rdya;

  // Distance from the rim in Q.8; two units or more means full occupancy.
  assign diff_c = {1'b0, circle_radius, 8'b0} - {1'b0, in_root};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdya) begin
      va <= in_valid;
    end
    if (rdya && in_valid) begin
      diffa <= diff_c[8:0];
      fulla <= |diff_c[16:9];
      sidea <= in_side;
    end
  end

  // Scale the ramp by the full occupancy level.
  assign prod_c = {9'b0, OCC_FULL} * {16'b0, diffa};

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdyb) begin
      vb <= va;
    end
    if (rdyb && va) begin
      prodb <= prod_c;
      fullb <= fulla;
      sideb <= sidea;
    end
  end

  // Round half up, then pick between outside, shape and border.
  assign round_c   = prodb + 25'd256;
  assign covered_c = sideb.in_grid &&
                     ((shape_mode == SHAPE_RECT) ? sideb.rect_hit : sideb.circ_hit);

  always_comb begin
    if (!sideb.in_grid) begin
      occ_c = 16'd0;
    end else if (covered_c) begin
      if (shape_mode == SHAPE_RECT || fullb) begin
        occ_c = OCC_FULL;
      end else begin
        occ_c = round_c[24:9];
      end
    end else if (sideb.border) begin
      occ_c = OCC_BORDER;
    end else begin
      occ_c = 16'd0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdyc) begin
      vc <= vb;
    end
    if (rdyc && vb) begin
      occupancy       <= occ_c;
      out_vel_x       <= covered_c ? vel_x : 16'sd0;
      out_vel_y       <= covered_c ? vel_y : 16'sd0;
      inside_obstacle <= covered_c;
    end
  end

  assign out_valid = vc;

endmodule

// File: src/omr_checker.sv
// Port-level checks for the obstacle mask rasterizer, bound to the top level.
// Depends on omr_pkg and obstacle_mask_rasterizer.
module omr_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        occupancy,
  input  logic signed [15:0] out_vel_x,
  input  logic signed [15:0] out_vel_y,
  input  logic               inside_obstacle
);
  import omr_pkg::*;

  // Reset empties the pipeline, so no result shows right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Uncovered pixels carry no velocity.
  a_zero_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_obstacle |-> out_vel_x == 16'sd0 && out_vel_y == 16'sd0)
    else $error("velocity on an uncovered pixel");

  // Uncovered pixels are either empty or border.
  a_bg_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_obstacle |-> occupancy == 16'd0 || occupancy == OCC_BORDER)
    else $error("unexpected background occupancy");

  // Covered pixels never exceed the full level.
  a_shape_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_obstacle |-> occupancy <= OCC_FULL)
    else $error("shape occupancy above full level");

endmodule

bind obstacle_mask_rasterizer omr_checker u_omr_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .occupancy       (occupancy),
  .out_vel_x       (out_vel_x),
  .out_vel_y       (out_vel_y),
  .inside_obstacle (inside_obstacle)
);

// File: tb/obstacle_mask_rasterizer_tb.sv
// Self-checking testbench for obstacle_mask_rasterizer: drives pixel transactions,
// predicts each texel from its own copy of the registers and checks every result.
// Depends on omr_pkg and the obstacle_mask_rasterizer RTL only.
module obstacle_mask_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import omr_pkg::*;

  localparam int GRID_W = 256;
  localparam int GRID_H = 256;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int SEGMENTS = 10;
  localparam int SEGMENT_PIXELS = 50;
  localparam logic [3:0] REG_UNUSED_FIRST = 4'd8;

  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
  } pixel_t;

  typedef struct {
    logic [15:0]        occ;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               covered;
  } texel_t;

  typedef struct {
    logic               shape;
    logic [9:0]         cx;
    logic [9:0]         cy;
    logic [7:0]         radius;
    logic [9:0]         hw;
    logic [9:0]         hh;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } obstacle_cfg_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [3:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [9:0]         pixel_x = '0;
  logic [9:0]         pixel_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        occupancy;
  logic signed [15:0] out_vel_x;
  logic signed [15:0] out_vel_y;
  logic               inside_obstacle;

  obstacle_cfg_t obstacle;
  pixel_t        pixel_queue[$];
  texel_t        texel_queue[$];
  pixel_t        next_pixel;
  pixel_t        fresh_pixel;
  texel_t        want;

  int   send_idle = 11;
  int   recv_idle = 84;
  int   items_queued = 0;
  int   items_accepted = 0;
  int   items_checked = 0;
  int   errors = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic in_taken = 1'b0;
  logic pressure_armed = 1'b0;
  logic pressure_done = 1'b0;

  obstacle_mask_rasterizer #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .occupancy      (occupancy),
    .out_vel_x      (out_vel_x),
    .out_vel_y      (out_vel_y),
    .inside_obstacle(inside_obstacle)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Floor of the square root, resolved one root bit at a time.
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Expected texel for one pixel under the current register copy.
  function automatic texel_t shade_pixel(logic [9:0] px, logic [9:0] py);
    texel_t          t;
    int              dx;
    int              dy;
    longint unsigned d2;
    longint unsigned rq;
    longint unsigned root_q8;
    longint unsigned diff;
    longint unsigned full;
    t = '{occ: '0, vx: '0, vy: '0, covered: 1'b0};
    if (int'(px) < GRID_W && int'(py) < GRID_H) begin
      if (px == 0 || py == 0 || int'(px) == GRID_W - 1 || int'(py) == GRID_H - 1)
        t.occ = OCC_BORDER;
      if (obstacle.shape == SHAPE_CIRCLE) begin
        dx = int'(px) - int'(obstacle.cx);
        dy = int'(py) - int'(obstacle.cy);
        d2 = longint'(dx) * dx + longint'(dy) * dy;
        rq = obstacle.radius;
        if (d2 <= rq * rq) begin
          // Q.8 distance; the last two pixels inside the rim ramp down to zero.
          root_q8 = int_root(d2 << 16);
          diff = (rq << 8) - root_q8;
          full = OCC_FULL;
          t.covered = 1'b1;
          if (diff >= 512) t.occ = OCC_FULL;
          else t.occ = 16'((full * diff + 256) >> 9);
        end
      end else begin
        if (int'(px) >= int'(obstacle.cx) - int'(obstacle.hw) &&
            int'(px) <  int'(obstacle.cx) + int'(obstacle.hw) &&
            int'(py) >= int'(obstacle.cy) - int'(obstacle.hh) &&
            int'(py) <  int'(obstacle.cy) + int'(obstacle.hh)) begin
          t.covered = 1'b1;
          t.occ = OCC_FULL;
        end
      end
      if (t.covered) begin
        t.vx = obstacle.vx;
        t.vy = obstacle.vy;
      end
    end
    return t;
  endfunction

  // Coordinate on or next to the grid border.
  function automatic logic [9:0] edge_coord();
    case ($urandom_range(4))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'(GRID_W - 2);
      3: return 10'(GRID_W - 1);
      default: return 10'(GRID_W);
    endcase
  endfunction

  // Random pixel, mostly around the shape and its rim so coverage and ramp are hit.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     ext_x;
    int     ext_y;
    int     ox;
    int     oy;
    int     r;
    int     k;
    r = obstacle.radius;
    ext_x = (obstacle.shape == SHAPE_CIRCLE) ? r : int'(obstacle.hw);
    ext_y = (obstacle.shape == SHAPE_CIRCLE) ? r : int'(obstacle.hh);
    k = $urandom_range(9);
    if (k < 4) begin
      ox = int'($urandom_range(2 * ext_x + 6)) - (ext_x + 3);
      oy = int'($urandom_range(2 * ext_y + 6)) - (ext_y + 3);
    end else if (k < 7 && obstacle.shape == SHAPE_CIRCLE) begin
      ox = int'($urandom_range(2 * r)) - r;
      oy = int'(int_root(longint'(r * r - ox * ox))) + int'($urandom_range(2)) - 1;
      if ($urandom_range(1)) oy = -oy;
    end else if (k < 7) begin
      ox = ($urandom_range(1) ? ext_x : -ext_x) - int'($urandom_range(1));
      oy = int'($urandom_range(2 * ext_y + 2)) - (ext_y + 1);
    end
    if (k < 7) begin
      p.x = 10'(int'(obstacle.cx) + ox);
      p.y = 10'(int'(obstacle.cy) + oy);
    end else if (k == 7) begin
      p.x = edge_coord();
      p.y = 10'($urandom_range(GRID_H));
      if ($urandom_range(1)) p = '{x: p.y, y: p.x};
    end else begin
      p.x = 10'($urandom);
      p.y = 10'($urandom);
    end
    return p;
  endfunction

  function automatic logic [9:0] pick_coord();
    case ($urandom_range(5))
      0: return 10'd0;
      1: return 10'd1023;
      2, 3: return 10'($urandom_range(GRID_W - 1));
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_half();
    case ($urandom_range(5))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'd1;
      default: return 10'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [15:0] pick_vel();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pixel(logic [9:0] x, logic [9:0] y);
    pixel_queue.push_back('{x: x, y: y});
    items_queued++;
  endtask

  // One register write on the configuration port, mirrored into the local copy.
  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SHAPE_MODE:    obstacle.shape  = data[0];
      REG_CENTER_X:      obstacle.cx     = data[9:0];
      REG_CENTER_Y:      obstacle.cy     = data[9:0];
      REG_CIRCLE_RADIUS: obstacle.radius = data[7:0];
      REG_HALF_WIDTH:    obstacle.hw     = data[9:0];
      REG_HALF_HEIGHT:   obstacle.hh     = data[9:0];
      REG_VEL_X:         obstacle.vx     = data;
      REG_VEL_Y:         obstacle.vy     = data;
      default: begin
      end
    endcase
  endtask

  // Writes every register, with junk in the unused upper bits, plus one unmapped index.
  task automatic program_obstacle(logic shape, logic [9:0] cx, logic [9:0] cy,
                                  logic [7:0] r, logic [9:0] hw, logic [9:0] hh,
                                  logic [15:0] vx, logic [15:0] vy);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_SHAPE_MODE, {junk[15:1], shape});
    write_reg(REG_CENTER_X, {junk[15:10], cx});
    write_reg(REG_CENTER_Y, {junk[14:9], cy});
    write_reg(REG_CIRCLE_RADIUS, {junk[7:0], r});
    write_reg(REG_HALF_WIDTH, {junk[13:8], hw});
    write_reg(REG_HALF_HEIGHT, {junk[12:7], hh});
    write_reg(REG_VEL_X, vx);
    write_reg(REG_VEL_Y, vy);
    write_reg(REG_UNUSED_FIRST + 4'($urandom_range(7)), 16'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every queued pixel has been accepted and its texel checked.
  task automatic drain();
    while (items_accepted != items_queued || items_checked != items_accepted)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Pixel driver: holds a stalled transaction, otherwise offers the next pixel or idles.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Stalled transaction keeps its payload.
    end else if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
      next_pixel = pixel_queue.pop_front();
      in_valid <= 1'b1;
      pixel_x  <= next_pixel.x;
      pixel_y  <= next_pixel.y;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls, and one long hold-off that fills the pipeline.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_armed && !pressure_done) begin
      out_stall     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Monitor: predicts on each accepted pixel and checks each accepted texel.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        texel_queue.push_back(shade_pixel(pixel_x, pixel_y));
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (texel_queue.size() == 0) begin
          $error("texel with no pixel pending: occupancy %0d", occupancy);
          errors++;
        end else begin
          want = texel_queue.pop_front();
          items_checked++;
          if (occupancy !== want.occ) begin
            $error("occupancy mismatch: expected %0d, actual %0d", want.occ, occupancy);
            errors++;
          end
          if (out_vel_x !== want.vx) begin
            $error("out_vel_x mismatch: expected %0d, actual %0d", want.vx, out_vel_x);
            errors++;
          end
          if (out_vel_y !== want.vy) begin
            $error("out_vel_y mismatch: expected %0d, actual %0d", want.vy, out_vel_y);
            errors++;
          end
          if (inside_obstacle !== want.covered) begin
            $error("inside_obstacle mismatch: expected %0d, actual %0d",
                   want.covered, inside_obstacle);
            errors++;
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("obstacle_mask_rasterizer verification failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    obstacle = '{shape: SHAPE_CIRCLE, cx: 10'd128, cy: 10'd128, radius: 8'd16,
                 hw: 10'd16, hh: 10'd16, vx: '0, vy: '0};
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: border, outside the grid, center, ramp and rim of the circle.
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd255, 10'd255);
    queue_pixel(10'd1023, 10'd1023);
    queue_pixel(10'd256, 10'd10);
    queue_pixel(10'd10, 10'd256);
    queue_pixel(10'd128, 10'd128);
    queue_pixel(10'd144, 10'd128);
    queue_pixel(10'd142, 10'd128);
    queue_pixel(10'd140, 10'd128);
    queue_pixel(10'd139, 10'd139);
    queue_pixel(10'd100, 10'd100);
    queue_pixel(10'd0, 10'd128);
    drain();

    // Radius one on the left border: the shape wins over the border value.
    program_obstacle(SHAPE_CIRCLE, 10'd0, 10'd5, 8'd1, 10'd0, 10'd0, 16'h7FFF, 16'h8000);
    queue_pixel(10'd0, 10'd5);
    queue_pixel(10'd1, 10'd5);
    queue_pixel(10'd0, 10'd7);
    drain();

    // Radius zero in the far corner.
    program_obstacle(SHAPE_CIRCLE, 10'd255, 10'd255, 8'd0, 10'd0, 10'd0, 16'h8000, 16'h7FFF);
    queue_pixel(10'd255, 10'd255);
    queue_pixel(10'd254, 10'd255);
    drain();

    // Rectangle clipped by the grid corner; exclusive upper bounds.
    program_obstacle(SHAPE_RECT, 10'd2, 10'd250, 8'd16, 10'd5, 10'd10, 16'h0123, 16'hFEDC);
    queue_pixel(10'd0, 10'd255);
    queue_pixel(10'd6, 10'd250);
    queue_pixel(10'd7, 10'd250);
    queue_pixel(10'd0, 10'd239);
    queue_pixel(10'd3, 10'd240);
    drain();

    // A zero half extent covers nothing.
    program_obstacle(SHAPE_RECT, 10'd2, 10'd250, 8'd16, 10'd0, 10'd10, 16'h0123, 16'hFEDC);
    queue_pixel(10'd2, 10'd250);
    drain();

    // Random segments: a few extreme settings first, then random ones.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        send_idle = 11;
        recv_idle = 84;
      end else if (seg < 7) begin
        send_idle = 84;
        recv_idle = 11;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (seg)
        0: program_obstacle(SHAPE_CIRCLE, 10'd0, 10'd1023, 8'd255, 10'd0, 10'd0,
                            16'h8000, 16'h7FFF);
        1: program_obstacle(SHAPE_RECT, 10'd1023, 10'd0, 8'd2, 10'd1023, 10'd1023,
                            16'h7FFF, 16'h8000);
        2: program_obstacle(SHAPE_CIRCLE, 10'd128, 10'd128, 8'd2, 10'd1, 10'd1,
                            pick_vel(), pick_vel());
        default: program_obstacle(1'($urandom), pick_coord(), pick_coord(),
                                  ($urandom_range(3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(2, 40)),
                                  pick_half(), pick_half(), pick_vel(), pick_vel());
      endcase
      if (seg == 7) pressure_armed <= 1'b1;
      for (int i = 0; i < SEGMENT_PIXELS; i++) begin
        fresh_pixel = random_pixel();
        queue_pixel(fresh_pixel.x, fresh_pixel.y);
      end
      drain();
    end

    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("obstacle_mask_rasterizer verification clean");
    end else begin
      $display("obstacle_mask_rasterizer verification failed");
    end
    $finish;
  end

endmodule
